FILE: design/ptrmx_pkg.sv
// Shared constants and types for the persistent trie range max-xor block.
package ptrmx_pkg;

   localparam int TOP_BIT_DEF      = 30;
   localparam int MAX_VERSIONS_DEF = 1023;
   localparam int NODE_DEPTH_DEF   = 32768;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // control from the sequencer to the level step unit
   typedef struct packed {
      logic query;
      logic leaf;
      logic key_bit;
   } step_ctl_type;

endpackage

FILE: design/ptrmx_ram.sv
// Simple dual-read, single-write RAM with registered reads; address 0 reads as zero.
module ptrmx_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [DATA_W-1:0]          rd_data_a,
   output logic [DATA_W-1:0]          rd_data_b
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] data_a_ff;
   logic [DATA_W-1:0] data_b_ff;
   logic              zero_a_ff;
   logic              zero_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      data_a_ff <= mem_ff[rd_addr_a];
      data_b_ff <= mem_ff[rd_addr_b];
      zero_a_ff <= (rd_addr_a == '0);
      zero_b_ff <= (rd_addr_b == '0);
   end

   // entry 0 is the null entry and is never written
   assign rd_data_a = zero_a_ff ? '0 : data_a_ff;
   assign rd_data_b = zero_b_ff ? '0 : data_b_ff;

endmodule

FILE: design/ptrmx_step.sv
// Level step unit: child select, count compare and path-copy record build.
module ptrmx_step import ptrmx_pkg::*; #(
   parameter int MAX_VERSIONS = MAX_VERSIONS_DEF,
   parameter int NODE_DEPTH   = NODE_DEPTH_DEF
) (
   input  step_ctl_type ctl,
   input  logic [2*$clog2(NODE_DEPTH)+2*$clog2(MAX_VERSIONS+1)-1:0] rec_a,
   input  logic [2*$clog2(NODE_DEPTH)+2*$clog2(MAX_VERSIONS+1)-1:0] rec_b,
   input  logic [$clog2(NODE_DEPTH)-1:0] new_id,
   output logic [$clog2(NODE_DEPTH)-1:0] next_a,
   output logic [$clog2(NODE_DEPTH)-1:0] next_b,
   output logic [2*$clog2(NODE_DEPTH)+2*$clog2(MAX_VERSIONS+1)-1:0] wr_data,
   output logic take_opp
);

   localparam int NODE_W = $clog2(NODE_DEPTH);
   localparam int VER_W  = $clog2(MAX_VERSIONS + 1);

   // record: {cnt1, cnt0, child1, child0}; counts belong to the children
   logic [NODE_W-1:0] a_kid [2];
   logic [NODE_W-1:0] b_kid [2];
   logic [VER_W-1:0]  a_cnt [2];
   logic [VER_W-1:0]  b_cnt [2];
   logic [NODE_W-1:0] w_kid [2];
   logic [VER_W-1:0]  w_cnt [2];
   logic              bit_k;
   logic              bit_o;

   assign a_kid[0] = rec_a[NODE_W-1:0];
   assign a_kid[1] = rec_a[2*NODE_W-1:NODE_W];
   assign a_cnt[0] = rec_a[2*NODE_W+VER_W-1:2*NODE_W];
   assign a_cnt[1] = rec_a[2*NODE_W+2*VER_W-1:2*NODE_W+VER_W];
   assign b_kid[0] = rec_b[NODE_W-1:0];
   assign b_kid[1] = rec_b[2*NODE_W-1:NODE_W];
   assign b_cnt[0] = rec_b[2*NODE_W+VER_W-1:2*NODE_W];
   assign b_cnt[1] = rec_b[2*NODE_W+2*VER_W-1:2*NODE_W+VER_W];

   assign bit_k = ctl.key_bit;
   assign bit_o = ~ctl.key_bit;

   always_comb begin
      take_opp = ctl.query && (b_cnt[bit_o] > a_cnt[bit_o]);
      next_a   = take_opp ? a_kid[bit_o] : a_kid[bit_k];
      next_b   = take_opp ? b_kid[bit_o] : b_kid[bit_k];

      w_kid[0] = a_kid[0];
      w_kid[1] = a_kid[1];
      w_cnt[0] = a_cnt[0];
      w_cnt[1] = a_cnt[1];
      // new nodes are numbered in path order, so the copied child is new_id + 1
      w_kid[bit_k] = new_id + NODE_W'(1);
      w_cnt[bit_k] = a_cnt[bit_k] + VER_W'(1);

      if (ctl.leaf) begin
         wr_data = rec_a;
      end else begin
         wr_data = {w_cnt[1], w_cnt[0], w_kid[1], w_kid[0]};
      end
   end

endmodule

FILE: design/persistent_trie_range_max_xor.sv
// Top level: persistent binary trie with range max-xor queries.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | action, key_value, lo_version, hi_version
//   rsp_    | out       | rsp_valid/rsp_stall | new_version, max_xor, status
//
// One item at a time. The accept cycle reads the root table, ST_ROOT issues the first node
// reads, then the walk runs one key bit per cycle (TOP_BIT+1 bits) through the level step
// unit, each bound by one dependent node-RAM read. Insert: walk, then ST_LEAF writes the
// leaf copy and commits the version, then ST_FINISH; query: walk, then ST_FINISH. Rejected
// items (store or version table full, bad range) go from accept straight to ST_FINISH.
// Reset is synchronous; node store and root table hold no reset, entry 0 reads as zero.
// req_stall is high while an item is in work; a result waiting on rsp_stall does not
// block the next accept, only the delivery of the next result.
module persistent_trie_range_max_xor import ptrmx_pkg::*; #(
   parameter int TOP_BIT      = TOP_BIT_DEF,
   parameter int MAX_VERSIONS = MAX_VERSIONS_DEF,
   parameter int NODE_DEPTH   = NODE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [TOP_BIT:0]                   req_key_value,
   input  logic [$clog2(MAX_VERSIONS+1)-1:0]  req_lo_version,
   input  logic [$clog2(MAX_VERSIONS+1)-1:0]  req_hi_version,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [$clog2(MAX_VERSIONS+1)-1:0]  rsp_new_version,
   output logic [TOP_BIT:0]                   rsp_max_xor,
   output logic [STATUS_W-1:0]                rsp_status
);

   localparam int KEY_W     = TOP_BIT + 1;
   localparam int IDX_W     = $clog2(KEY_W);
   localparam int NODE_W    = $clog2(NODE_DEPTH);
   localparam int VER_W     = $clog2(MAX_VERSIONS + 1);
   localparam int REC_W     = 2 * NODE_W + 2 * VER_W;
   localparam int NODE_NEED = TOP_BIT + 2;   // fresh nodes per insert

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROOT   = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_LEAF   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [NODE_W-1:0]   nodes_used_ff, nodes_used_in;
   logic [VER_W-1:0]    vt_ff, vt_in;          // latest version number
   logic                rsp_valid_ff, rsp_valid_in;

   // item in work
   logic                action_ff, action_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;        // key bit of the current level
   logic [NODE_W-1:0]   node_ff, node_in;      // id of the node being written
   logic [KEY_W-1:0]    best_ff, best_in;
   logic [VER_W-1:0]    res_ver_ff, res_ver_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   // output register
   logic [VER_W-1:0]    rsp_ver_ff, rsp_ver_in;
   logic [KEY_W-1:0]    rsp_xor_ff, rsp_xor_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // memories and step unit
   logic [NODE_W-1:0]   root_a, root_b;
   logic [VER_W-1:0]    root_rd_a;
   logic                root_wr_en;
   logic [REC_W-1:0]    rec_a, rec_b;
   logic [NODE_W-1:0]   node_rd_a, node_rd_b;
   logic                node_wr_en;
   logic [REC_W-1:0]    step_wr_data;
   logic [NODE_W-1:0]   step_next_a, step_next_b;
   logic                take_opp;
   step_ctl_type        step_ctl;

   logic                store_full;
   logic                ver_full;
   logic                bad_range;

   assign store_full = ({1'b0, nodes_used_ff} + (NODE_W+1)'(NODE_NEED)) >
                       (NODE_W+1)'(NODE_DEPTH - 1);
   assign ver_full   = (vt_ff >= VER_W'(MAX_VERSIONS));
   assign bad_range  = (req_lo_version > req_hi_version) || (req_hi_version > vt_ff);

   // roots are read in the accept cycle: insert needs the latest root, query lo and hi
   assign root_rd_a  = (req_action == ACT_QUERY) ? req_lo_version : vt_ff;
   assign root_wr_en = (state_ff == ST_LEAF);

   ptrmx_ram #(
      .DATA_W (NODE_W),
      .DEPTH  (MAX_VERSIONS + 1)
   ) u_roots (
      .clock     (clock),
      .wr_en     (root_wr_en),
      .wr_addr   (vt_ff + VER_W'(1)),
      .wr_data   (nodes_used_ff + NODE_W'(1)),
      .rd_addr_a (root_rd_a),
      .rd_addr_b (req_hi_version),
      .rd_data_a (root_a),
      .rd_data_b (root_b)
   );

   // walk starts at the roots, then follows what the step unit selects
   assign node_rd_a  = (state_ff == ST_ROOT) ? root_a : step_next_a;
   assign node_rd_b  = (state_ff == ST_ROOT) ? root_b : step_next_b;
   assign node_wr_en = ((state_ff == ST_WALK) && (action_ff == ACT_INSERT)) ||
                       (state_ff == ST_LEAF);

   ptrmx_ram #(
      .DATA_W (REC_W),
      .DEPTH  (NODE_DEPTH)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (node_wr_en),
      .wr_addr   (node_ff),
      .wr_data   (step_wr_data),
      .rd_addr_a (node_rd_a),
      .rd_addr_b (node_rd_b),
      .rd_data_a (rec_a),
      .rd_data_b (rec_b)
   );

   assign step_ctl.query   = (action_ff == ACT_QUERY);
   assign step_ctl.leaf    = (state_ff == ST_LEAF);
   assign step_ctl.key_bit = key_ff[idx_ff];

   ptrmx_step #(
      .MAX_VERSIONS (MAX_VERSIONS),
      .NODE_DEPTH   (NODE_DEPTH)
   ) u_step (
      .ctl      (step_ctl),
      .rec_a    (rec_a),
      .rec_b    (rec_b),
      .new_id   (node_ff),
      .next_a   (step_next_a),
      .next_b   (step_next_b),
      .wr_data  (step_wr_data),
      .take_opp (take_opp)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      nodes_used_in = nodes_used_ff;
      vt_in         = vt_ff;
      rsp_valid_in  = rsp_valid_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      node_in       = node_ff;
      best_in       = best_ff;
      res_ver_in    = res_ver_ff;
      res_status_in = res_status_ff;
      rsp_ver_in    = rsp_ver_ff;
      rsp_xor_in    = rsp_xor_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in     = req_action;
               key_in        = req_key_value;
               idx_in        = IDX_W'(TOP_BIT);
               node_in       = nodes_used_ff + NODE_W'(1);
               best_in       = '0;
               res_ver_in    = '0;
               res_status_in = STATUS_OK;
               if ((req_action == ACT_INSERT) && (ver_full || store_full)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_FINISH;
               end else if ((req_action == ACT_QUERY) && bad_range) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (action_ff == ACT_QUERY) begin
               best_in[idx_ff] = take_opp;
            end else begin
               node_in = node_ff + NODE_W'(1);
            end
            if (idx_ff == '0) begin
               state_in = (action_ff == ACT_QUERY) ? ST_FINISH : ST_LEAF;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_LEAF: begin
            // leaf copy written this cycle; commit the new version
            vt_in         = vt_ff + VER_W'(1);
            nodes_used_in = node_ff;
            res_ver_in    = vt_ff + VER_W'(1);
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ver_in    = res_ver_ff;
               rsp_xor_in    = best_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nodes_used_ff <= '0;
         vt_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         vt_ff         <= vt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      node_ff       <= node_in;
      best_ff       <= best_in;
      res_ver_ff    <= res_ver_in;
      res_status_ff <= res_status_in;
      rsp_ver_ff    <= rsp_ver_in;
      rsp_xor_ff    <= rsp_xor_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_version = rsp_ver_ff;
   assign rsp_max_xor     = rsp_xor_ff;
   assign rsp_status      = rsp_status_ff;

   // a new result is only loaded out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish state");

   // allocation never runs past the node store
   a_nodes_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, nodes_used_ff} <= (NODE_W+1)'(NODE_DEPTH - 1))
      else $error("node store overrun");

   // an insert only reaches its leaf when a version slot is free
   a_leaf_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAF) |-> (vt_ff < VER_W'(MAX_VERSIONS)))
      else $error("insert committed past version limit");

endmodule
